// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/ntwa_pkg.sv
// Package with the request and result types and status codes of the neighbor table.
`default_nettype none
package ntwa_pkg;
	localparam logic [1:0] ST_REFRESH = 2'd0;
	localparam logic [1:0] ST_INSERT  = 2'd1;
	localparam logic [1:0] ST_DROP    = 2'd2;
	localparam logic [1:0] ST_SWEEP   = 2'd3;
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_SWEEP = 1'b1;
	localparam logic [1:0] REG_EXPIRY = 2'd0;
	localparam logic [15:0] EXPIRY_RESET = 16'd60;

	typedef struct packed {
		logic        operation;
		logic [63:0] machine_id_hi;
		logic [63:0] machine_id_lo;
		logic [3:0]  port;
		logic [47:0] remote_mac;
		logic [31:0] remote_ipv4;
		logic [63:0] remote_ipv6_hi;
		logic [63:0] remote_ipv6_lo;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       new_machine;
		logic [8:0] expired_count;
		logic [8:0] active_entries;
	} rsp_t;

	typedef struct packed {
		logic clr;
		logic step;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic match;
		logic hit;
		logic have_free;
	} sts_t;
endpackage
`default_nettype wire

// File: rtl/ntwa_datapath.sv
// Datapath: entry memories, valid bits, scan index, match and expiry logic.
`default_nettype none
module ntwa_datapath #(
	parameter int TABLE_ENTRIES = 256,
	parameter int PORT_COUNT = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ntwa_pkg::req_t      req,
	input  wire logic [15:0]         expiry,
	input  wire ntwa_pkg::cmd_t      cmd,
	output ntwa_pkg::sts_t           sts,
	output logic [8:0]               expired_count,
	output logic [8:0]               active_entries,
	output logic                     port_bad
);
	localparam int AW = $clog2(TABLE_ENTRIES);

	logic [63:0] mem_mhi [TABLE_ENTRIES];
	logic [63:0] mem_mlo [TABLE_ENTRIES];
	logic [3:0]  mem_port [TABLE_ENTRIES];
	logic [47:0] mem_mac [TABLE_ENTRIES];
	logic [31:0] mem_ipv4 [TABLE_ENTRIES];
	logic [63:0] mem_v6hi [TABLE_ENTRIES];
	logic [63:0] mem_v6lo [TABLE_ENTRIES];
	logic [31:0] mem_seen [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [AW-1:0] idx_q, rd_idx_q, slot_q, free_q;
	logic          rd_vld_q;
	logic [63:0]   rd_mhi_q, rd_mlo_q;
	logic [3:0]    rd_port_q;
	logic [31:0]   rd_seen_q;
	logic          rd_valid_q;
	logic          hit_q, free_found_q, seen_q;
	logic [8:0]    exp_q, total_q;
	logic          mm, pm, old;
	logic [31:0]   age;

	assign mm  = rd_valid_q && rd_mhi_q == req.machine_id_hi && rd_mlo_q == req.machine_id_lo;
	assign pm  = mm && rd_port_q == req.port;
	assign age = req.now_seconds - rd_seen_q;
	assign old = rd_valid_q && age > {16'd0, expiry};
	assign port_bad = {28'd0, req.port} >= 32'(PORT_COUNT);

	always_ff @(posedge clk) begin
		rd_mhi_q  <= mem_mhi[idx_q];
		rd_mlo_q  <= mem_mlo[idx_q];
		rd_port_q <= mem_port[idx_q];
		rd_seen_q <= mem_seen[idx_q];
		if (cmd.write) begin
			if (!hit_q) begin
				mem_mhi[free_q]  <= req.machine_id_hi;
				mem_mlo[free_q]  <= req.machine_id_lo;
				mem_port[free_q] <= req.port;
			end
			mem_mac[hit_q ? slot_q : free_q]  <= req.remote_mac;
			mem_ipv4[hit_q ? slot_q : free_q] <= req.remote_ipv4;
			mem_v6hi[hit_q ? slot_q : free_q] <= req.remote_ipv6_hi;
			mem_v6lo[hit_q ? slot_q : free_q] <= req.remote_ipv6_lo;
			mem_seen[hit_q ? slot_q : free_q] <= req.now_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q <= '0;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			rd_valid_q <= 1'b0;
			slot_q <= '0;
			free_q <= '0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			seen_q <= 1'b0;
			exp_q <= '0;
			total_q <= '0;
		end else if (cmd.clr) begin
			idx_q <= '0;
			rd_vld_q <= 1'b0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			seen_q <= 1'b0;
			exp_q <= '0;
		end else begin
			if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
				rd_idx_q <= idx_q;
				rd_valid_q <= valid_q[idx_q];
				rd_vld_q <= 1'b1;
			end else begin
				rd_vld_q <= 1'b0;
			end
			if (rd_vld_q) begin
				if (req.operation == ntwa_pkg::OP_SWEEP) begin
					if (old) begin
						valid_q[rd_idx_q] <= 1'b0;
						exp_q <= exp_q + 9'd1;
						total_q <= total_q - 9'd1;
					end
				end else begin
					if (mm) seen_q <= 1'b1;
					if (pm && !hit_q) begin
						hit_q <= 1'b1;
						slot_q <= rd_idx_q;
					end
					if (!rd_valid_q && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= rd_idx_q;
					end
				end
			end
			if (cmd.write && !hit_q) begin
				valid_q[free_q] <= 1'b1;
				total_q <= total_q + 9'd1;
			end
		end
	end

	assign sts.last = rd_vld_q && !cmd.step;
	assign sts.match = seen_q;
	assign sts.hit = hit_q;
	assign sts.have_free = free_found_q;
	assign expired_count = exp_q;
	assign active_entries = total_q;
endmodule
`default_nettype wire

// File: rtl/ntwa_ctrl.sv
// Controller: scan sequencing, update decision and result register.
`default_nettype none
module ntwa_ctrl #(
	parameter int TABLE_ENTRIES = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           op,
	input  wire logic           port_bad,
	input  wire ntwa_pkg::sts_t sts,
	input  wire logic [8:0]     expired_count,
	input  wire logic [8:0]     active_entries,
	output ntwa_pkg::cmd_t      cmd,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ntwa_pkg::rsp_t      rsp
);
	localparam int CW = $clog2(TABLE_ENTRIES) + 1;
	typedef enum logic [2:0] {IDLE, SCAN, DRAIN, DECIDE, WRITE, DONE} state_t;
	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] st_q;

	assign in_ready = state_q == IDLE && !out_valid;
	assign cmd.clr = state_q == IDLE;
	assign cmd.step = state_q == SCAN;
	assign cmd.write = state_q == WRITE &&
		(st_q == ntwa_pkg::ST_REFRESH || st_q == ntwa_pkg::ST_INSERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			st_q <= ntwa_pkg::ST_REFRESH;
			out_valid <= 1'b0;
			rsp <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: begin
					cnt_q <= '0;
					if (in_valid && in_ready) state_q <= SCAN;
				end
				SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(TABLE_ENTRIES - 1)) state_q <= DRAIN;
				end
				DRAIN: state_q <= DECIDE;
				DECIDE: begin
					if (op == ntwa_pkg::OP_SWEEP) st_q <= ntwa_pkg::ST_SWEEP;
					else if (port_bad) st_q <= ntwa_pkg::ST_DROP;
					else if (sts.hit) st_q <= ntwa_pkg::ST_REFRESH;
					else if (sts.have_free) st_q <= ntwa_pkg::ST_INSERT;
					else st_q <= ntwa_pkg::ST_DROP;
					state_q <= WRITE;
				end
				WRITE: state_q <= DONE;
				DONE: begin
					rsp.status <= st_q;
					rsp.new_machine <= op == ntwa_pkg::OP_STORE && !sts.match;
					rsp.expired_count <= op == ntwa_pkg::OP_SWEEP ? expired_count : 9'd0;
					rsp.active_entries <= active_entries;
					out_valid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/neighbor_table_with_aging.sv
// Top level of the neighbor table with aging.
// Channel | Direction | Handshake
// in      | input     | in_valid / in_ready, payload in_data
// out     | output    | out_valid / out_ready, payload out_data
// cfg     | input     | APB write of expiry_seconds
// Each request scans every table entry in turn, then passes through DRAIN, DECIDE, WRITE and DONE.
// The result register is loaded in DONE, and out_valid rises as the controller returns to IDLE.
// A new request is taken only once the previous result has been delivered.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled result holds its output register until out_ready.
`default_nettype none
module neighbor_table_with_aging #(
	parameter int TABLE_ENTRIES = 256,
	parameter int PORT_COUNT = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ntwa_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ntwa_pkg::rsp_t      out_data,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [1:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	ntwa_pkg::req_t req_q;
	ntwa_pkg::cmd_t cmd;
	ntwa_pkg::sts_t sts;
	logic [15:0] expiry_q;
	logic [8:0] exp_cnt, act_cnt;
	logic port_bad;

	assign pready = 1'b1;
	assign prdata = paddr == ntwa_pkg::REG_EXPIRY ? {16'd0, expiry_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) expiry_q <= ntwa_pkg::EXPIRY_RESET;
		else if (psel && penable && pwrite && paddr == ntwa_pkg::REG_EXPIRY)
			expiry_q <= pwdata[15:0];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
	end

	ntwa_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .PORT_COUNT(PORT_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req_q), .expiry(expiry_q), .cmd(cmd), .sts(sts),
		.expired_count(exp_cnt), .active_entries(act_cnt), .port_bad(port_bad)
	);

	ntwa_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(req_q.operation), .port_bad(port_bad), .sts(sts), .expired_count(exp_cnt),
		.active_entries(act_cnt), .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
		.rsp(out_data)
	);
endmodule
`default_nettype wire

// File: rtl/ntwa_checker.sv
// Port checker for the neighbor table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ntwa_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire ntwa_pkg::rsp_t out_data
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, !in_ready, "request taken while result pending")
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid, "accept not followed by busy")
	`ASSERT_IMPL(a_sweep_fields, clk, arst_n, out_valid && out_data.status == ntwa_pkg::ST_SWEEP, !out_data.new_machine, "sweep reports new machine")
endmodule
bind neighbor_table_with_aging ntwa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
